// ----- hdl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types, sizes and codes of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeaderBytes = 48;
  localparam int unsigned AlignBytes  = 16;

  localparam int unsigned AddrW = 20;
  localparam int unsigned SizeW = 21;
  localparam int unsigned CntW  = $clog2(MaxBlocks + 1);

  localparam logic [SizeW-1:0] HeapReset = SizeW'(4096);
  localparam logic [SizeW-1:0] HeapMin   = SizeW'(64);
  localparam logic [SizeW-1:0] HeapMax   = SizeW'(1048576);

  // request kinds on the input tuser
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // result status codes on the output tuser
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StOom      = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StDouble   = 2'd3;

  // one block table entry
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] size;
    logic             free;
  } entry_t;

endpackage

// ----- hdl/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// one slot of the block table, loads its neighbour's entry on every shift
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic            clk_i,
  input  logic            shift_en_i,
  input  ffba_pkg::entry_t d_i,
  output ffba_pkg::entry_t q_o
);

  ffba_pkg::entry_t q_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

// ----- hdl/ffba_chain.sv -----
// ----------------------------------------------------------------------------
// ffba_chain
// row of table cells shifting towards the head, refilled at the tail
// ----------------------------------------------------------------------------
module ffba_chain (
  input  logic             clk_i,
  input  logic             shift_en_i,
  input  ffba_pkg::entry_t tail_i,
  output ffba_pkg::entry_t head_o
);

  ffba_pkg::entry_t cell_q [ffba_pkg::MaxBlocks];

  for (genvar g = 0; g < ffba_pkg::MaxBlocks; g++) begin : g_cell
    ffba_pkg::entry_t d;
    if (g == ffba_pkg::MaxBlocks - 1) begin : g_tail
      assign d = tail_i;
    end else begin : g_mid
      assign d = cell_q[g+1];
    end
    ffba_cell u_cell (
      .clk_i     (clk_i),
      .shift_en_i(shift_en_i),
      .d_i       (d),
      .q_o       (cell_q[g])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap allocator with split and coalescing over a rotating table
// ----------------------------------------------------------------------------
// sequence: an allocate takes one table pass, then loads the result beat; a free
// takes one pass plus one extra pass for each free neighbour merged; one request
// is in work at a time, and the next one waits while a result beat is held off
// reset: table holds one free block of 4096 bytes less the header, total zero;
// a heap_size write sets that state for the clamped new size at once, no clearing pass
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config register heap_size
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i,
  // request beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // req_size[20:0], req_addr[40:21], zero pad
  input  logic        s_axis_tuser_i,  // req_type
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // result_addr[19:0], allocated_bytes[40:20], pad
  output logic [1:0]  m_axis_tuser_o   // status
);

  localparam int unsigned SizeW = ffba_pkg::SizeW;
  localparam int unsigned AddrW = ffba_pkg::AddrW;
  localparam int unsigned CntW  = ffba_pkg::CntW;

  localparam logic [CntW-1:0]  LastT  = CntW'(ffba_pkg::MaxBlocks);
  localparam logic [SizeW-1:0] HdrSz  = SizeW'(ffba_pkg::HeaderBytes);
  localparam logic [SizeW:0]   AlignM = (SizeW+1)'(ffba_pkg::AlignBytes - 1);

  // controller states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPass  = 2'd1;
  localparam logic [1:0] StDeliv = 2'd2;

  // pass kinds
  localparam logic [1:0] KAlloc = 2'd0;
  localparam logic [1:0] KFree  = 2'd1;
  localparam logic [1:0] KCoal  = 2'd2;

  // stream modes: lag by one, lag by two after a split, direct after a merge
  localparam logic [1:0] MLag    = 2'd0;
  localparam logic [1:0] MLag2   = 2'd1;
  localparam logic [1:0] MDirect = 2'd2;

  logic [1:0]       st_q, st_d;
  logic [1:0]       kind_q, kind_d;
  logic [1:0]       mode_q, mode_d;
  logic [CntW-1:0]  t_q, t_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SizeW-1:0] used_q, used_d;
  logic [SizeW-1:0] heap_q, heap_d;
  logic             fresh_q, fresh_d;
  logic             found_q, found_d;
  logic             chk_next_q, chk_next_d;
  logic [1:0]       merges_q, merges_d;
  logic [SizeW:0]   need_q, need_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [1:0]       status_q, status_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  ffba_pkg::entry_t h_q, h_d, h2_q, h2_d;

  logic             ovalid_q, ovalid_d;
  logic [AddrW-1:0] oaddr_q, oaddr_d;
  logic [1:0]       ostat_q, ostat_d;
  logic [SizeW-1:0] oused_q, oused_d;

  ffba_pkg::entry_t head, ein, tail;
  logic             in_vld, fit, split, match;
  logic [SizeW:0]   need_sum;
  logic [SizeW-1:0] grant, cfg_clamped;

  ffba_chain u_chain (
    .clk_i     (clk_i),
    .shift_en_i(st_q == StPass),
    .tail_i    (tail),
    .head_o    (head)
  );

  // rounded size of the incoming request
  assign need_sum = {1'b0, s_axis_tdata_i[SizeW-1:0]} + AlignM;

  always_comb begin
    // after reset or config the table is implied: one free block at offset zero
    ein = head;
    if (t_q == '0 && fresh_q) begin
      ein.start = '0;
      ein.size  = heap_q - HdrSz;
      ein.free  = 1'b1;
    end
    in_vld = t_q < count_q;
    fit    = ein.free && ({1'b0, ein.size} >= need_q);
    split  = ({1'b0, ein.size} > (need_q + (SizeW+1)'(ffba_pkg::HeaderBytes)))
             && (count_q < LastT);
    match  = ({1'b0, ein.start} + HdrSz) == {1'b0, addr_q};
    grant  = split ? need_q[SizeW-1:0] : ein.size;

    cfg_clamped = cfg_wdata_i;
    if (cfg_wdata_i < ffba_pkg::HeapMin) cfg_clamped = ffba_pkg::HeapMin;
    if (cfg_wdata_i > ffba_pkg::HeapMax) cfg_clamped = ffba_pkg::HeapMax;
  end

  always_comb begin
    st_d       = st_q;
    kind_d     = kind_q;
    mode_d     = mode_q;
    t_d        = t_q;
    count_d    = count_q;
    used_d     = used_q;
    heap_d     = heap_q;
    fresh_d    = fresh_q;
    found_d    = found_q;
    chk_next_d = chk_next_q;
    merges_d   = merges_q;
    need_d     = need_q;
    addr_d     = addr_q;
    status_d   = status_q;
    raddr_d    = raddr_q;
    h_d        = h_q;
    h2_d       = h2_q;
    ovalid_d   = ovalid_q && !m_axis_tready_i;
    oaddr_d    = oaddr_q;
    ostat_d    = ostat_q;
    oused_d    = oused_q;
    tail       = h_q;

    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          st_d       = StPass;
          kind_d     = (s_axis_tuser_i == ffba_pkg::ReqFree) ? KFree : KAlloc;
          need_d     = need_sum & ~AlignM;
          addr_d     = s_axis_tdata_i[SizeW+AddrW-1:SizeW];
          status_d   = (s_axis_tuser_i == ffba_pkg::ReqFree) ? ffba_pkg::StNotFound
                                                             : ffba_pkg::StOom;
          raddr_d    = '0;
          t_d        = '0;
          mode_d     = MLag;
          found_d    = 1'b0;
          merges_d   = '0;
          chk_next_d = 1'b0;
        end
      end

      StPass: begin
        t_d = t_q + 1'b1;
        if (t_q == '0) fresh_d = 1'b0;

        // default streaming per mode
        case (mode_q)
          MLag: begin
            tail = h_q;
            h_d  = ein;
          end
          MLag2: begin
            tail = h_q;
            h_d  = h2_q;
            h2_d = ein;
          end
          default: begin
            tail = ein;
          end
        endcase

        case (kind_q)
          KAlloc: begin
            if (!found_q && in_vld && fit) begin
              found_d  = 1'b1;
              status_d = ffba_pkg::StOk;
              raddr_d  = ein.start + AddrW'(ffba_pkg::HeaderBytes);
              used_d   = used_q + grant;
              h_d      = ein;
              h_d.free = 1'b0;
              if (split) begin
                // allocated part, then the free remainder behind its header
                h_d.size   = need_q[SizeW-1:0];
                h2_d.start = ein.start + AddrW'(ffba_pkg::HeaderBytes)
                             + need_q[AddrW-1:0];
                h2_d.size  = ein.size - need_q[SizeW-1:0] - HdrSz;
                h2_d.free  = 1'b1;
                mode_d     = MLag2;
                count_d    = count_q + 1'b1;
              end
            end
          end
          KFree: begin
            chk_next_d = 1'b0;
            if (chk_next_q && in_vld && ein.free) merges_d = merges_q + 1'b1;
            if (!found_q && in_vld && match) begin
              found_d = 1'b1;
              if (ein.free) begin
                status_d = ffba_pkg::StDouble;
              end else begin
                status_d   = ffba_pkg::StOk;
                h_d.free   = 1'b1;
                used_d     = (used_q >= ein.size) ? used_q - ein.size : '0;
                chk_next_d = 1'b1;
                if (t_q != '0 && h_q.free) merges_d = merges_q + 1'b1;
              end
            end
          end
          default: begin
            // coalesce the first adjacent pair of free blocks
            if (!found_q && t_q != '0 && in_vld && h_q.free && ein.free) begin
              found_d   = 1'b1;
              tail      = h_q;
              tail.size = h_q.size + HdrSz + ein.size;
              mode_d    = MDirect;
              count_d   = count_q - 1'b1;
            end
          end
        endcase

        if (t_q == LastT) begin
          if (merges_q != '0) begin
            kind_d   = KCoal;
            merges_d = merges_q - 1'b1;
            t_d      = '0;
            mode_d   = MLag;
            found_d  = 1'b0;
          end else begin
            st_d = StDeliv;
          end
        end
      end

      StDeliv: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          oaddr_d  = raddr_q;
          ostat_d  = status_q;
          oused_d  = used_q;
          st_d     = StIdle;
        end
      end

      default: begin
        st_d = StIdle;
      end
    endcase

    // a heap_size write reinitialises the table
    if (cfg_we_i) begin
      heap_d  = cfg_clamped;
      fresh_d = 1'b1;
      count_d = CntW'(1);
      used_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      kind_q     <= KAlloc;
      mode_q     <= MLag;
      t_q        <= '0;
      count_q    <= CntW'(1);
      used_q     <= '0;
      heap_q     <= ffba_pkg::HeapReset;
      fresh_q    <= 1'b1;
      found_q    <= 1'b0;
      chk_next_q <= 1'b0;
      merges_q   <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      st_q       <= st_d;
      kind_q     <= kind_d;
      mode_q     <= mode_d;
      t_q        <= t_d;
      count_q    <= count_d;
      used_q     <= used_d;
      heap_q     <= heap_d;
      fresh_q    <= fresh_d;
      found_q    <= found_d;
      chk_next_q <= chk_next_d;
      merges_q   <= merges_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    addr_q   <= addr_d;
    status_q <= status_d;
    raddr_q  <= raddr_d;
    h_q      <= h_d;
    h2_q     <= h2_d;
    oaddr_q  <= oaddr_d;
    ostat_q  <= ostat_d;
    oused_q  <= oused_d;
  end

  assign s_axis_tready_o = (st_q == StIdle);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {7'd0, oused_q, oaddr_q};
  assign m_axis_tuser_o  = ostat_q;

endmodule

// ----- hdl/ffba_chk.sv -----
// ----------------------------------------------------------------------------
// ffba_chk
// port-level checks of the first-fit block allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffba_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // one request at a time: an accepted beat closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still open after accepted beat");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // failed requests grant no offset
  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ffba_pkg::StOk |-> m_axis_tdata_o[19:0] == 20'd0)
    else $error("offset returned on failed request");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[47:41] == 7'd0)
    else $error("result pad bits set");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (.*);
